// File: src/eag_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eag_pkg
// Types, codes and helpers shared by the effective address generator.
// ----------------------------------------------------------------------------
package eag_pkg;

  localparam int RF_DEPTH = 16;
  localparam int RF_AW    = 4;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_ADDR  = 2'd1,
    REQ_DATA  = 2'd2,
    REQ_READ  = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    KIND_FINAL   = 2'd0,
    KIND_REQ     = 2'd1,
    KIND_REG     = 2'd2,
    KIND_INVALID = 2'd3
  } kind_t;

  localparam logic [2:0] MODE_IND     = 3'd2;
  localparam logic [2:0] MODE_POSTINC = 3'd3;
  localparam logic [2:0] MODE_PREDEC  = 3'd4;
  localparam logic [2:0] MODE_DISP    = 3'd5;
  localparam logic [2:0] MODE_INDEX   = 3'd6;
  localparam logic [2:0] MODE_SPECIAL = 3'd7;

  localparam logic [2:0] SUB_ABS_W    = 3'd0;
  localparam logic [2:0] SUB_ABS_L    = 3'd1;
  localparam logic [2:0] SUB_PC_DISP  = 3'd2;
  localparam logic [2:0] SUB_PC_INDEX = 3'd3;
  localparam logic [2:0] SUB_IMM      = 3'd4;

  localparam logic [2:0] STACK_REG    = 3'd7;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [2:0]  mode;
    logic [2:0]  reg_num;
    logic [3:0]  size_bytes;
    logic [15:0] ext_first;
    logic [63:0] following_words;
    logic [31:0] pc_value;
    logic [3:0]  reg_select;
    logic [31:0] data_value;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  result_kind;
    logic [31:0] address;
    logic [3:0]  pc_advance;
  } out_word_t;

  typedef struct packed {
    logic             en;
    logic [RF_AW-1:0] addr;
    logic [31:0]      data;
  } rf_wr_t;

  typedef struct packed {
    logic        active;
    logic [31:0] index;
    logic [31:0] outer;
    logic        post;
    logic [3:0]  advance;
  } pend_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sx8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

endpackage
`default_nettype wire

// File: src/eag_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eag_ram
// Generic RAM with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module eag_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_a,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr_b,
  output logic      [WIDTH-1:0]         rd_data_a,
  output logic      [WIDTH-1:0]         rd_data_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule
`default_nettype wire

// File: src/eag_regfile.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eag_regfile
// Data and address registers held in a RAM, with valid bits so that an
// unwritten register reads as zero, and bypass of a same-cycle write.
// ----------------------------------------------------------------------------
module eag_regfile
  import eag_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             rd_en,
  input  wire logic [RF_AW-1:0] rd_addr_a,
  input  wire logic [RF_AW-1:0] rd_addr_b,
  input  wire rf_wr_t           wr,
  output logic      [31:0]      rd_data_a,
  output logic      [31:0]      rd_data_b
);

  logic [RF_DEPTH-1:0] vld;
  logic                vld_a;
  logic                vld_b;
  logic [RF_AW-1:0]    addr_a;
  logic [RF_AW-1:0]    addr_b;
  rf_wr_t              fwd;
  logic [31:0]         ram_a;
  logic [31:0]         ram_b;

  eag_ram #(
    .WIDTH(32),
    .DEPTH(RF_DEPTH)
  ) u_ram (
    .clk       (clk),
    .wr_en     (wr.en),
    .wr_addr   (wr.addr),
    .wr_data   (wr.data),
    .rd_en     (rd_en),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (rd_addr_b),
    .rd_data_a (ram_a),
    .rd_data_b (ram_b)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      fwd.en <= 1'b0;
    end else begin
      if (wr.en) begin
        vld[wr.addr] <= 1'b1;
      end
      if (rd_en) begin
        fwd.en   <= wr.en;
        fwd.addr <= wr.addr;
        fwd.data <= wr.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      vld_a  <= vld[rd_addr_a];
      vld_b  <= vld[rd_addr_b];
      addr_a <= rd_addr_a;
      addr_b <= rd_addr_b;
    end
  end

  always_comb begin
    if (fwd.en && fwd.addr == addr_a) begin
      rd_data_a = fwd.data;
    end else begin
      rd_data_a = vld_a ? ram_a : 32'd0;
    end
    if (fwd.en && fwd.addr == addr_b) begin
      rd_data_b = fwd.data;
    end else begin
      rd_data_b = vld_b ? ram_b : 32'd0;
    end
  end

endmodule
`default_nettype wire

// File: src/eag_calc.sv
`default_nettype none
// ----------------------------------------------------------------------------
// eag_calc
// Address arithmetic for one word: decodes the mode, forms the result,
// the register write-back and the next indirection state.
// ----------------------------------------------------------------------------
module eag_calc
  import eag_pkg::*;
(
  input  wire in_word_t    item,
  input  wire logic [31:0] base_val,
  input  wire logic [31:0] index_val,
  input  wire pend_t       pend,
  output logic             res_valid,
  output out_word_t        res,
  output rf_wr_t           wr,
  output pend_t            pend_next
);

  logic [15:0] ext;
  logic [15:0] w0, w1, w2, w3;
  logic [15:0] wa, wb;
  logic [4:0]  step;
  logic [31:0] idx;
  logic [31:0] ext_base;
  logic [31:0] full_base;
  logic [31:0] full_idx;
  logic [31:0] bd, od;
  logic [1:0]  kb, ko;
  logic [2:0]  ksum;
  logic [3:0]  adv;
  logic [31:0] brief_addr;
  logic [31:0] pre_sum;
  logic        is_full;
  logic        is_indirect;

  assign ext = item.ext_first;
  assign w0  = item.following_words[63:48];
  assign w1  = item.following_words[47:32];
  assign w2  = item.following_words[31:16];
  assign w3  = item.following_words[15:0];

  always_comb begin
    step = {1'b0, item.size_bytes} +
           ((item.reg_num == STACK_REG && item.size_bytes == 4'd1) ? 5'd1 : 5'd0);

    idx = ext[11] ? index_val : sx16(index_val[15:0]);
    idx = idx << ext[10:9];

    ext_base   = (item.mode == MODE_SPECIAL) ? item.pc_value : base_val;
    brief_addr = ext_base + sx8(ext[7:0]) + idx;
    full_base  = ext[7] ? 32'd0 : ext_base;
    full_idx   = ext[6] ? 32'd0 : idx;

    case (ext[5:4])
      2'd2: begin
        bd = sx16(w0);
        kb = 2'd1;
      end
      2'd3: begin
        bd = {w0, w1};
        kb = 2'd2;
      end
      default: begin
        bd = 32'd0;
        kb = 2'd0;
      end
    endcase

    case (kb)
      2'd0: begin
        wa = w0;
        wb = w1;
      end
      2'd1: begin
        wa = w1;
        wb = w2;
      end
      default: begin
        wa = w2;
        wb = w3;
      end
    endcase

    case (ext[1:0])
      2'd2: begin
        od = sx16(wa);
        ko = 2'd1;
      end
      2'd3: begin
        od = {wa, wb};
        ko = 2'd2;
      end
      default: begin
        od = 32'd0;
        ko = 2'd0;
      end
    endcase

    ksum        = {1'b0, kb} + {1'b0, ko};
    adv         = 4'd2 + {ksum, 1'b0};
    pre_sum     = full_base + bd;
    is_full     = ext[8];
    is_indirect = ext[1:0] != 2'd0;
  end

  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    wr        = '0;
    pend_next = pend;
    case (req_t'(item.req_type))
      REQ_WRITE: begin
        wr.en   = 1'b1;
        wr.addr = item.reg_select;
        wr.data = item.data_value;
      end
      REQ_READ: begin
        res_valid       = 1'b1;
        res.result_kind = KIND_REG;
        res.address     = base_val;
      end
      REQ_DATA: begin
        if (pend.active) begin
          pend_next.active = 1'b0;
          res_valid        = 1'b1;
          res.result_kind  = KIND_FINAL;
          res.address      = item.data_value + (pend.post ? pend.index : 32'd0) + pend.outer;
          res.pc_advance   = pend.advance;
        end
      end
      default: begin
        pend_next.active = 1'b0;
        res_valid        = 1'b1;
        res.result_kind  = KIND_FINAL;
        if (item.mode == MODE_INDEX ||
            (item.mode == MODE_SPECIAL && item.reg_num == SUB_PC_INDEX)) begin
          if (!is_full) begin
            res.address    = brief_addr;
            res.pc_advance = 4'd2;
          end else if (!is_indirect) begin
            res.address    = pre_sum + full_idx;
            res.pc_advance = adv;
          end else begin
            res.result_kind   = KIND_REQ;
            res.address       = ext[2] ? pre_sum : pre_sum + full_idx;
            res.pc_advance    = adv;
            pend_next.active  = 1'b1;
            pend_next.index   = full_idx;
            pend_next.outer   = od;
            pend_next.post    = ext[2];
            pend_next.advance = adv;
          end
        end else begin
          case (item.mode)
            MODE_IND: begin
              res.address = base_val;
            end
            MODE_POSTINC: begin
              res.address = base_val;
              wr.en       = 1'b1;
              wr.addr     = {1'b1, item.reg_num};
              wr.data     = base_val + {27'd0, step};
            end
            MODE_PREDEC: begin
              res.address = base_val - {27'd0, step};
              wr.en       = 1'b1;
              wr.addr     = {1'b1, item.reg_num};
              wr.data     = base_val - {27'd0, step};
            end
            MODE_DISP: begin
              res.address    = base_val + sx16(ext);
              res.pc_advance = 4'd2;
            end
            MODE_SPECIAL: begin
              case (item.reg_num)
                SUB_ABS_W: begin
                  res.address    = sx16(ext);
                  res.pc_advance = 4'd2;
                end
                SUB_ABS_L: begin
                  res.address    = {ext, w0};
                  res.pc_advance = 4'd4;
                end
                SUB_PC_DISP: begin
                  res.address    = item.pc_value + sx16(ext);
                  res.pc_advance = 4'd2;
                end
                SUB_IMM: begin
                  if (item.size_bytes == 4'd1) begin
                    res.address    = item.pc_value + 32'd1;
                    res.pc_advance = 4'd2;
                  end else begin
                    res.address    = item.pc_value;
                    res.pc_advance = item.size_bytes;
                  end
                end
                default: begin
                  res.result_kind = KIND_INVALID;
                end
              endcase
            end
            default: begin
              res.result_kind = KIND_INVALID;
            end
          endcase
        end
      end
    endcase
  end

endmodule
`default_nettype wire

// File: src/effective_address_generator_unit.sv
`default_nettype none
// The accepted word and its register file read data are registered into stage
// s1, and the result formed there is registered into out_word.
// Throughput: one word per cycle unless the output stalls; the register file
// RAM is read on acceptance and its write port is used by the following stage.
// Reset: synchronous; all registers read as zero, the pending indirection
// and both pipeline stages are cleared, and a word is taken straight away.
// ----------------------------------------------------------------------------
// effective_address_generator_unit
// Effective address generation for the memory addressing modes,
// with register file access and memory-indirect completion.
// ----------------------------------------------------------------------------
module effective_address_generator_unit
  import eag_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_word_t  in_word,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_word_t      out_word
);

  logic             accept;
  logic             s1_valid;
  logic             s1_fire;
  in_word_t         s1_word;
  logic [RF_AW-1:0] rd_addr_a;
  logic [31:0]      rd_data_a;
  logic [31:0]      rd_data_b;
  rf_wr_t           calc_wr;
  rf_wr_t           rf_wr;
  pend_t            pend;
  pend_t            pend_next;
  logic             res_valid;
  out_word_t        res;

  assign s1_fire  = s1_valid && (!out_valid || !out_stall);
  assign in_stall = s1_valid && !s1_fire;
  assign accept   = in_valid && !in_stall;

  assign rd_addr_a = (in_word.req_type == REQ_READ) ? in_word.reg_select
                                                    : {1'b1, in_word.reg_num};

  always_comb begin
    rf_wr    = calc_wr;
    rf_wr.en = calc_wr.en && s1_fire;
  end

  eag_regfile u_regfile (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (accept),
    .rd_addr_a (rd_addr_a),
    .rd_addr_b (in_word.ext_first[15:12]),
    .wr        (rf_wr),
    .rd_data_a (rd_data_a),
    .rd_data_b (rd_data_b)
  );

  eag_calc u_calc (
    .item      (s1_word),
    .base_val  (rd_data_a),
    .index_val (rd_data_b),
    .pend      (pend),
    .res_valid (res_valid),
    .res       (res),
    .wr        (calc_wr),
    .pend_next (pend_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      out_valid <= 1'b0;
      pend      <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
      end else if (s1_fire) begin
        s1_valid <= 1'b0;
      end
      if (s1_fire) begin
        out_valid <= res_valid;
        pend      <= pend_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_word <= in_word;
    end
    if (s1_fire) begin
      out_word <= res;
    end
  end

`ifndef SYNTHESIS
  a_reset_empty : assert property (@(posedge clk) rst |=> !out_valid && !s1_valid)
    else $error("Pipeline not empty after reset.");

  a_stall_cause : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_fire) |-> (out_valid && out_stall))
    else $error("Stage held without a stalled output word.");

  a_req_pending : assert property (@(posedge clk) disable iff (rst)
    (s1_fire && res_valid && res.result_kind == KIND_REQ) |=> pend.active)
    else $error("Indirect request issued without pending state.");

  a_stall_valid : assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("Input stalled with an empty stage.");
`endif

endmodule
`default_nettype wire
